### hw/rtl/dtq_pkg.sv
// ----------------------------------------------------------------------------
// dtq_pkg: types and constants of the deadline timer queue
// Request and reply beats, opcode and reply kind codes, cell commands.
// ----------------------------------------------------------------------------
package dtq_pkg;

	localparam int CNT_W  = 31;
	localparam int TASK_W = 8;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_TIME  = 2'd1,
		OP_DELAY = 2'd2,
		OP_UNTIL = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		K_ACK  = 3'd0,
		K_TIME = 3'd1,
		K_WAKE = 3'd2,
		K_PAST = 3'd3,
		K_FULL = 3'd4
	} kind_t;

	typedef struct packed {
		opcode_t            opcode;
		logic [TASK_W-1:0]  task_id;
		logic [CNT_W-1:0]   amount;
	} request_t;

	typedef struct packed {
		logic [TASK_W-1:0]  reply_task;
		kind_t              reply_kind;
		logic [CNT_W-1:0]   tick_value;
		logic               last;
	} reply_t;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_POP    = 2'd2
	} cell_op_t;

	typedef struct packed {
		cell_op_t          op;
		logic [CNT_W-1:0]  deadline;
	} cell_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_INSERT = 2'd1,
		ST_WAKE   = 2'd2
	} state_t;

endpackage

### hw/rtl/dtq_cell.sv
// ----------------------------------------------------------------------------
// dtq_cell: one slot of the sorted waiter chain
// Holds one deadline and task; inserts in order or shifts towards the head.
// ----------------------------------------------------------------------------
module dtq_cell #(
	parameter int TB = 8
) (
	input  logic                     clk,
	input  dtq_pkg::cell_cmd_t       cmd,
	input  logic [TB-1:0]            new_task,
	input  logic                     occupied,
	input  logic                     prev_keep,
	input  logic [dtq_pkg::CNT_W-1:0] prev_deadline,
	input  logic [TB-1:0]            prev_task,
	input  logic [dtq_pkg::CNT_W-1:0] next_deadline,
	input  logic [TB-1:0]            next_task,
	output logic                     keep,
	output logic [dtq_pkg::CNT_W-1:0] deadline,
	output logic [TB-1:0]            task_id
);
	import dtq_pkg::*;

	logic [CNT_W-1:0] deadline_q;
	logic [TB-1:0]    task_q;

	assign keep     = occupied && (deadline_q <= cmd.deadline);
	assign deadline = deadline_q;
	assign task_id  = task_q;

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			CELL_INSERT: begin
				if (!keep) begin
					if (prev_keep) begin
						deadline_q <= cmd.deadline;
						task_q     <= new_task;
					end else begin
						deadline_q <= prev_deadline;
						task_q     <= prev_task;
					end
				end
			end
			CELL_POP: begin
				deadline_q <= next_deadline;
				task_q     <= next_task;
			end
			default: begin
			end
		endcase
	end

endmodule

### hw/rtl/deadline_timer_queue_core.sv
// ----------------------------------------------------------------------------
// deadline_timer_queue_core: tick counter with a sorted queue of waiters
// Requests enter as one beat on request, taken when start is high and busy
// is low. Replies leave as one beat on reply, valid for the single cycle in
// which strobe is high; the receiver cannot hold them off.
// Replies: every reply is registered, driven from strobe_q and reply_q.
// A time query, a past deadline or a full queue gives its one reply in the
// cycle after acceptance; the block is free again at once.
// A delay or until request that queues gives no reply and keeps busy high
// while the chain of cells shifts the new waiter into place.
// A tick gives its ack in the cycle after acceptance, then one wakeup per
// cycle, soonest first, popped from the head of the chain: a tick that
// wakes waiters keeps busy high while it pops them.
// Reset clears the tick count and empties the queue; no clearing pass.
// ----------------------------------------------------------------------------
module deadline_timer_queue_core #(
	parameter int QUEUE_DEPTH  = 32,
	parameter int TASK_ID_BITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  dtq_pkg::request_t request,
	output logic              strobe,
	output dtq_pkg::reply_t   reply
);
	import dtq_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int TB = (TASK_ID_BITS < TASK_W) ? TASK_ID_BITS : TASK_W;

	state_t           state_q, state_d;
	logic [CW-1:0]    count_q, count_d;
	logic [CNT_W-1:0] tick_q, tick_d;
	logic             strobe_q, strobe_d;
	reply_t           reply_q, reply_d;
	logic [CNT_W-1:0] ins_deadline_q;
	logic [TB-1:0]    ins_task_q;

	cell_cmd_t        cmd;
	logic [TB-1:0]    req_task;
	logic             accept;
	logic [CNT_W-1:0] tick_next;
	logic [CNT_W:0]   rel_sum;
	logic [CNT_W-1:0] new_deadline;
	logic             head_due_next;
	logic             second_due;

	logic [CNT_W-1:0] cell_deadline [QUEUE_DEPTH];
	logic [TB-1:0]    cell_task     [QUEUE_DEPTH];
	logic             cell_keep     [QUEUE_DEPTH];

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign req_task = request.task_id[TB-1:0];
	assign strobe   = strobe_q;
	assign reply    = reply_q;

	assign tick_next     = (tick_q == CNT_MAX) ? tick_q : tick_q + 1'b1;
	assign rel_sum       = {1'b0, tick_q} + {1'b0, request.amount};
	assign new_deadline  = (request.opcode == OP_DELAY)
	                       ? (rel_sum[CNT_W] ? CNT_MAX : rel_sum[CNT_W-1:0])
	                       : request.amount;
	assign head_due_next = (count_q != '0) && (cell_deadline[0] <= tick_next);
	assign second_due    = (count_q > CW'(1)) && (cell_deadline[1] <= tick_q);

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic             p_keep;
		logic [CNT_W-1:0] p_deadline, n_deadline;
		logic [TB-1:0]    p_task, n_task;

		if (i == 0) begin : g_first
			assign p_keep     = 1'b1;
			assign p_deadline = cell_deadline[i];
			assign p_task     = cell_task[i];
		end else begin : g_mid
			assign p_keep     = cell_keep[i-1];
			assign p_deadline = cell_deadline[i-1];
			assign p_task     = cell_task[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_end
			assign n_deadline = cell_deadline[i];
			assign n_task     = cell_task[i];
		end else begin : g_inner
			assign n_deadline = cell_deadline[i+1];
			assign n_task     = cell_task[i+1];
		end

		dtq_cell #(
			.TB (TB)
		) u_cell (
			.clk           (clk),
			.cmd           (cmd),
			.new_task      (ins_task_q),
			.occupied      (CW'(i) < count_q),
			.prev_keep     (p_keep),
			.prev_deadline (p_deadline),
			.prev_task     (p_task),
			.next_deadline (n_deadline),
			.next_task     (n_task),
			.keep          (cell_keep[i]),
			.deadline      (cell_deadline[i]),
			.task_id       (cell_task[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			tick_q   <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			tick_q   <= tick_d;
			strobe_q <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		reply_q <= reply_d;
		if (accept) begin
			ins_deadline_q <= new_deadline;
			ins_task_q     <= req_task;
		end
	end

	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		tick_d       = tick_q;
		strobe_d     = 1'b0;
		reply_d      = reply_q;
		cmd.op       = CELL_HOLD;
		cmd.deadline = ins_deadline_q;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					reply_d.reply_task = TASK_W'(req_task);
					reply_d.tick_value = tick_q;
					reply_d.last       = 1'b1;
					unique case (request.opcode)
						OP_TICK: begin
							tick_d             = tick_next;
							strobe_d           = 1'b1;
							reply_d.reply_kind = K_ACK;
							reply_d.tick_value = '0;
							reply_d.last       = !head_due_next;
							if (head_due_next)
								state_d = ST_WAKE;
						end
						OP_TIME: begin
							strobe_d           = 1'b1;
							reply_d.reply_kind = K_TIME;
						end
						default: begin
							if (new_deadline < tick_q) begin
								strobe_d           = 1'b1;
								reply_d.reply_kind = K_PAST;
							end else if (count_q >= CW'(QUEUE_DEPTH)) begin
								strobe_d           = 1'b1;
								reply_d.reply_kind = K_FULL;
							end else begin
								state_d = ST_INSERT;
							end
						end
					endcase
				end
			end
			ST_INSERT: begin
				cmd.op  = CELL_INSERT;
				count_d = count_q + 1'b1;
				state_d = ST_IDLE;
			end
			ST_WAKE: begin
				cmd.op             = CELL_POP;
				count_d            = count_q - 1'b1;
				strobe_d           = 1'b1;
				reply_d.reply_task = TASK_W'(cell_task[0]);
				reply_d.reply_kind = K_WAKE;
				reply_d.tick_value = tick_q;
				reply_d.last       = !second_due;
				if (!second_due)
					state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
